[rtl/core/sem_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sem_pkg
// Shared widths, register decode codes and pipeline item types for the
// sobel edge magnitude block.
// ----------------------------------------------------------------------------
package sem_pkg;

  localparam int MAX_WIDTH  = 512;
  localparam int MAX_HEIGHT = 4096;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int PIX_W      = 8;
  localparam int FW_W       = 10;
  localparam int FH_W       = 13;
  localparam int GRAD_W     = 11;
  localparam int SQ_W       = 16;
  localparam int SQSUM_W    = 21;
  localparam int SQRT_STEPS = SQ_W / 2;
  localparam int STEPS_PER_STAGE = 2;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  localparam logic [FW_W-1:0] FW_RESET = FW_W'(512);
  localparam logic [FH_W-1:0] FH_RESET = FH_W'(512);

  typedef enum logic {
    CFG_IDX_WIDTH  = 1'b0,
    CFG_IDX_HEIGHT = 1'b1
  } sem_cfg_idx_t;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             last;
  } sem_meta_t;

  typedef struct packed {
    logic            valid;
    logic            sat;
    logic [SQ_W-1:0] sq;
    sem_meta_t       meta;
  } sem_sq_t;

  typedef struct packed {
    logic             valid;
    logic [PIX_W-1:0] mag;
    sem_meta_t        meta;
  } sem_mag_t;

endpackage
`default_nettype wire

[rtl/core/sem_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sem_if
// Valid/ready channels of the sobel edge magnitude block: pixel input and
// gradient result output.
// ----------------------------------------------------------------------------
interface sem_pix_if;
  import sem_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

interface sem_res_if;
  import sem_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] magnitude;
  logic [COL_W-1:0] out_col;
  logic [ROW_W-1:0] out_row;
  logic             last_result;

  modport source (output valid, output magnitude, output out_col, output out_row,
                  output last_result, input ready);
  modport sink   (input valid, input magnitude, input out_col, input out_row,
                  input last_result, output ready);
endinterface
`default_nettype wire

[rtl/core/sem_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sem_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module sem_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

[rtl/core/sem_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sem_front
// Raster counters, line store, 3x3 window, sobel gradients and squared
// magnitude. The line store keeps the two previous rows packed per column.
// ----------------------------------------------------------------------------
module sem_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      take,
  input  logic [sem_pkg::PIX_W-1:0] pixel,
  input  logic [sem_pkg::FW_W-1:0]  frame_width,
  input  logic [sem_pkg::FH_W-1:0]  frame_height,
  output sem_pkg::sem_sq_t          sq_o
);
  import sem_pkg::*;

  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [COL_W-1:0] last_col;
  logic [ROW_W-1:0] last_row;
  logic             emit;
  sem_meta_t        meta;

  // item waiting for line store data
  logic             v1_r;
  logic             emit1_r;
  logic [PIX_W-1:0] p1_r;
  logic [COL_W-1:0] col1_r;
  sem_meta_t        meta1_r;

  logic [2*PIX_W-1:0] ram_rd_data;
  logic [PIX_W-1:0]   top_pix, mid_pix;

  logic [PIX_W-1:0] win_r   [3][3];
  logic [PIX_W-1:0] win_nxt [3][3];

  logic signed [GRAD_W-1:0] gx, gy;
  logic                     v2_r;
  logic signed [GRAD_W-1:0] gx2_r, gy2_r;
  sem_meta_t                meta2_r;

  logic signed [2*GRAD_W-1:0] gx_sq, gy_sq;
  logic [SQSUM_W-1:0]         sq_sum;
  sem_sq_t                    sq_r;

  // effective frame bounds
  always_comb begin
    if (frame_width < FW_W'(3)) begin
      last_col = COL_W'(2);
    end else if (frame_width > FW_W'(MAX_WIDTH)) begin
      last_col = COL_W'(MAX_WIDTH - 1);
    end else begin
      last_col = COL_W'(frame_width - FW_W'(1));
    end
    if (frame_height < FH_W'(3)) begin
      last_row = ROW_W'(2);
    end else if (frame_height > FH_W'(MAX_HEIGHT)) begin
      last_row = ROW_W'(MAX_HEIGHT - 1);
    end else begin
      last_row = ROW_W'(frame_height - FH_W'(1));
    end
  end

  always_comb begin
    emit      = (col_r >= COL_W'(2)) && (row_r >= ROW_W'(2));
    meta.col  = col_r - COL_W'(1);
    meta.row  = row_r - ROW_W'(1);
    meta.last = (row_r >= last_row) && (col_r >= last_col);
    if (col_r >= last_col) begin
      col_nxt = '0;
      row_nxt = (row_r >= last_row) ? '0 : row_r + ROW_W'(1);
    end else begin
      col_nxt = col_r + COL_W'(1);
      row_nxt = row_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (take) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      emit1_r <= emit;
      p1_r    <= pixel;
      col1_r  <= col_r;
      meta1_r <= meta;
    end
  end

  // read at accept, write back when the pipeline advances; a column is read
  // again no sooner than the third item after, so no forwarding is needed
  sem_ram #(
    .WIDTH (2*PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (en && v1_r),
    .wr_addr (col1_r),
    .wr_data ({mid_pix, p1_r}),
    .rd_en   (take),
    .rd_addr (col_r),
    .rd_data (ram_rd_data)
  );

  assign top_pix = ram_rd_data[2*PIX_W-1:PIX_W];
  assign mid_pix = ram_rd_data[PIX_W-1:0];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_nxt[r][0] = win_r[r][1];
      win_nxt[r][1] = win_r[r][2];
    end
    win_nxt[0][2] = top_pix;
    win_nxt[1][2] = mid_pix;
    win_nxt[2][2] = p1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_r[r][c] <= '0;
        end
      end
    end else if (en && v1_r) begin
      win_r <= win_nxt;
    end
  end

  always_comb begin
    gx = $signed(GRAD_W'(win_nxt[0][2]) + (GRAD_W'(win_nxt[1][2]) << 1)
                 + GRAD_W'(win_nxt[2][2]))
       - $signed(GRAD_W'(win_nxt[0][0]) + (GRAD_W'(win_nxt[1][0]) << 1)
                 + GRAD_W'(win_nxt[2][0]));
    gy = $signed(GRAD_W'(win_nxt[2][0]) + (GRAD_W'(win_nxt[2][1]) << 1)
                 + GRAD_W'(win_nxt[2][2]))
       - $signed(GRAD_W'(win_nxt[0][0]) + (GRAD_W'(win_nxt[0][1]) << 1)
                 + GRAD_W'(win_nxt[0][2]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r && emit1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      gx2_r   <= gx;
      gy2_r   <= gy;
      meta2_r <= meta1_r;
    end
  end

  assign gx_sq  = gx2_r * gx2_r;
  assign gy_sq  = gy2_r * gy2_r;
  assign sq_sum = SQSUM_W'(gx_sq) + SQSUM_W'(gy_sq);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_r.valid <= 1'b0;
    end else if (en) begin
      sq_r.valid <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_r.sat  <= |sq_sum[SQSUM_W-1:SQ_W];
      sq_r.sq   <= sq_sum[SQ_W-1:0];
      sq_r.meta <= meta2_r;
    end
  end

  assign sq_o = sq_r;

endmodule
`default_nettype wire

[rtl/core/sem_sqrt.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sem_sqrt
// Pipelined integer square root, two result bits per stage, with
// saturation to the largest pixel value.
// ----------------------------------------------------------------------------
module sem_sqrt (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  sem_pkg::sem_sq_t sq_i,
  output sem_pkg::sem_mag_t mag_o
);
  import sem_pkg::*;

  localparam int NSTAGE = SQRT_STEPS / STEPS_PER_STAGE;

  typedef struct packed {
    logic            valid;
    logic            sat;
    logic [SQ_W-1:0] rem;
    logic [SQ_W-1:0] root;
    sem_meta_t       meta;
  } sqrt_stage_t;

  sqrt_stage_t st_in  [NSTAGE];
  sqrt_stage_t st_nxt [NSTAGE];
  sqrt_stage_t st_r   [NSTAGE];

  always_comb begin
    st_in[0].valid = sq_i.valid;
    st_in[0].sat   = sq_i.sat;
    st_in[0].rem   = sq_i.sq;
    st_in[0].root  = '0;
    st_in[0].meta  = sq_i.meta;
  end

  for (genvar g = 0; g < NSTAGE; g++) begin : g_stage
    if (g > 0) begin : g_link
      assign st_in[g] = st_r[g-1];
    end

    always_comb begin
      logic [SQ_W-1:0] bitv;
      logic [SQ_W:0]   trial;
      st_nxt[g] = st_in[g];
      for (int k = 0; k < STEPS_PER_STAGE; k++) begin
        bitv  = SQ_W'(1) << (SQ_W - 2 - 2 * (g * STEPS_PER_STAGE + k));
        trial = {1'b0, st_nxt[g].root} + {1'b0, bitv};
        if ({1'b0, st_nxt[g].rem} >= trial) begin
          st_nxt[g].rem  = st_nxt[g].rem - trial[SQ_W-1:0];
          st_nxt[g].root = (st_nxt[g].root >> 1) + bitv;
        end else begin
          st_nxt[g].root = st_nxt[g].root >> 1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        st_r[g].valid <= 1'b0;
      end else if (en) begin
        st_r[g] <= st_nxt[g];
      end
    end
  end

  always_comb begin
    mag_o.valid = st_r[NSTAGE-1].valid;
    mag_o.mag   = st_r[NSTAGE-1].sat ? {PIX_W{1'b1}} : st_r[NSTAGE-1].root[PIX_W-1:0];
    mag_o.meta  = st_r[NSTAGE-1].meta;
  end

endmodule
`default_nettype wire

[rtl/core/sobel_edge_magnitude.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sobel_edge_magnitude
// Streaming 3x3 sobel gradient magnitude over a raster pixel stream.
// ----------------------------------------------------------------------------
// Takes one pixel per clock unless stalled and gives floor(sqrt(gx^2+gy^2)),
// saturated at 255, for every interior pixel with its column, row and an
// end-of-frame flag; border pixels give no result. The two previous rows live
// in one 512 x 16 line store RAM, read when a pixel is taken and written back
// from the item register as the pipeline advances; the square root is a
// four-stage pipeline. The whole pipeline stalls only while a result sits
// unread in the output register. No clearing pass after reset: unwritten
// entries reach only input rows 0 and 1, which give no result. The user must
// write frame width and height over the APB port only while idle (unchecked).
module sobel_edge_magnitude (
  input  logic                        clk,
  input  logic                        rst_n,
  sem_pix_if.sink                     in_pix,
  sem_res_if.source                   out_res,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [sem_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [sem_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [sem_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                        cfg_pready
);
  import sem_pkg::*;

  logic [FW_W-1:0] frame_width_r;
  logic [FH_W-1:0] frame_height_r;
  logic            cfg_wr;
  sem_cfg_idx_t    cfg_idx;

  logic     en;
  logic     take;
  sem_sq_t  sq;
  sem_mag_t mag;

  logic             out_valid_r;
  logic [PIX_W-1:0] out_mag_r;
  logic [COL_W-1:0] out_col_r;
  logic [ROW_W-1:0] out_row_r;
  logic             out_last_r;

  // configuration
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = sem_cfg_idx_t'(cfg_paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FW_RESET;
      frame_height_r <= FH_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        CFG_IDX_WIDTH:  frame_width_r  <= cfg_pwdata[FW_W-1:0];
        CFG_IDX_HEIGHT: frame_height_r <= cfg_pwdata[FH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      CFG_IDX_WIDTH:  cfg_prdata = CFG_DW'(frame_width_r);
      CFG_IDX_HEIGHT: cfg_prdata = CFG_DW'(frame_height_r);
      default:        cfg_prdata = '0;
    endcase
  end

  // global pipeline advance
  assign en           = !out_valid_r || out_res.ready;
  assign in_pix.ready = en;
  assign take         = in_pix.valid && en;

  sem_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (en),
    .take         (take),
    .pixel        (in_pix.pixel),
    .frame_width  (frame_width_r),
    .frame_height (frame_height_r),
    .sq_o         (sq)
  );

  sem_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .sq_i  (sq),
    .mag_o (mag)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= mag.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_mag_r  <= mag.mag;
      out_col_r  <= mag.meta.col;
      out_row_r  <= mag.meta.row;
      out_last_r <= mag.meta.last;
    end
  end

  assign out_res.valid       = out_valid_r;
  assign out_res.magnitude   = out_mag_r;
  assign out_res.out_col     = out_col_r;
  assign out_res.out_row     = out_row_r;
  assign out_res.last_result = out_last_r;

  // interior pixels only
  a_interior_only : assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid |-> (out_res.out_col != '0) && (out_res.out_row != '0))
    else $error("result for a border pixel");

  // input is held off only while a result waits
  a_stall_holds_result : assert property (@(posedge clk) disable iff (!rst_n)
    !in_pix.ready |=> out_res.valid)
    else $error("stall without a pending result");

endmodule
`default_nettype wire
